[rtl/brf_pkg.sv]
`timescale 1ns / 1ps
// brf_pkg: shared widths, operation codes, register map and config struct
// for the byte ring FIFO. No dependencies.
package brf_pkg;

  localparam int CAP_W           = 12;
  localparam int DATA_W          = 8;
  localparam int FUNC_W          = 3;
  localparam int DEF_STORE_DEPTH = 4096;
  localparam int CAP_MAX_VAL     = (1 << CAP_W) - 1;

  localparam int PDATA_W   = 32;
  localparam int ADDR_W    = 3;
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = '0;

  localparam logic [FUNC_W-1:0] FUNC_WRITE   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEEK    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CONSUME = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_RESET   = 3'd4;

  typedef struct packed {
    logic             flush;
    logic [CAP_W-1:0] capacity;
  } cfg_t;

endpackage

[rtl/byte_ring_fifo_with_peak_unit.sv]
`timescale 1ns / 1ps
// Byte ring FIFO with peak-fill statistic. An accepted item goes through CALC,
// then FETCH for a read or peek that returns a byte (byte store read); the
// result strobe is registered. No new item is taken while busy; busy covers the
// pointer update and the synchronous store read. Results cannot be stalled.
// Reset: pointers and peak zero, capacity max; store contents undefined.
module byte_ring_fifo_with_peak_unit import brf_pkg::*; #(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [FUNC_W-1:0]  func,
  input  logic [DATA_W-1:0]  data_in,
  input  logic [CAP_W-1:0]   count,
  output logic               res_valid,
  output logic [DATA_W-1:0]  data_out,
  output logic [CAP_W-1:0]   done_res,
  output logic [CAP_W-1:0]   fill_level,
  output logic [CAP_W-1:0]   free_space,
  output logic [CAP_W-1:0]   peak_fill,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int AW = $clog2(STORE_DEPTH);

  cfg_t              cfg;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] mem_rdata;

  brf_cfg #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  brf_ctrl #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .start      (start),
    .func       (func),
    .data_in    (data_in),
    .count      (count),
    .busy       (busy),
    .res_valid  (res_valid),
    .data_out   (data_out),
    .done_res   (done_res),
    .fill_level (fill_level),
    .free_space (free_space),
    .peak_fill  (peak_fill),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  brf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

[rtl/brf_ram.sv]
`timescale 1ns / 1ps
// brf_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/brf_cfg.sv]
`timescale 1ns / 1ps
// brf_cfg: APB-style register port holding the clamped capacity and
// signalling a flush on each capacity write. Depends on brf_pkg.
module brf_cfg import brf_pkg::*; #(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  localparam logic [CAP_W-1:0] MAX_CAP =
    (STORE_DEPTH - 1 > CAP_MAX_VAL) ? CAP_W'(CAP_MAX_VAL) : CAP_W'(STORE_DEPTH - 1);

  logic             sel_cap;
  logic             wr;
  logic [CAP_W-1:0] raw;
  logic [CAP_W-1:0] clamped;
  logic [CAP_W-1:0] capacity;

  assign sel_cap = (paddr[ADDR_W-1:2] == REG_CAPACITY);
  assign wr      = psel & penable & pwrite & sel_cap;
  assign raw     = pwdata[CAP_W-1:0];

  always_comb begin
    priority if (raw == '0) begin
      clamped = CAP_W'(1);
    end else if (raw > MAX_CAP) begin
      clamped = MAX_CAP;
    end else begin
      clamped = raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= MAX_CAP;
    end else if (wr) begin
      capacity <= clamped;
    end
  end

  assign pready       = 1'b1;
  assign prdata       = sel_cap ? PDATA_W'(capacity) : '0;
  assign cfg.flush    = wr;
  assign cfg.capacity = capacity;

endmodule

[rtl/brf_ctrl.sv]
`timescale 1ns / 1ps
// brf_ctrl: operation sequencer; keeps the ring pointers and peak, drives the
// byte store and registers each result. Depends on brf_pkg.
module brf_ctrl import brf_pkg::*; #(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cfg_t                           cfg,
  input  logic                           start,
  input  logic [FUNC_W-1:0]              func,
  input  logic [DATA_W-1:0]              data_in,
  input  logic [CAP_W-1:0]               count,
  output logic                           busy,
  output logic                           res_valid,
  output logic [DATA_W-1:0]              data_out,
  output logic [CAP_W-1:0]               done_res,
  output logic [CAP_W-1:0]               fill_level,
  output logic [CAP_W-1:0]               free_space,
  output logic [CAP_W-1:0]               peak_fill,
  output logic                           mem_we,
  output logic [$clog2(STORE_DEPTH)-1:0] mem_waddr,
  output logic [DATA_W-1:0]              mem_wdata,
  output logic                           mem_re,
  output logic [$clog2(STORE_DEPTH)-1:0] mem_raddr,
  input  logic [DATA_W-1:0]              mem_rdata
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int SW = ((AW > CAP_W) ? AW : CAP_W) + 2;

  typedef enum logic [2:0] {
    IDLE  = 3'b001,
    CALC  = 3'b010,
    FETCH = 3'b100
  } state_t;

  state_t state, state_next;

  logic [AW-1:0]     wp, wp_next;
  logic [AW-1:0]     rp, rp_next;
  logic [CAP_W-1:0]  peak, peak_next;
  logic [FUNC_W-1:0] op_func;
  logic [DATA_W-1:0] op_data;
  logic [CAP_W-1:0]  op_count;

  logic              res_valid_next;
  logic [DATA_W-1:0] dout, dout_next;
  logic [CAP_W-1:0]  done_q, fill_q, free_q;

  logic [SW-1:0] wp_e, rp_e, cap_e, len, cnt_e;
  logic [SW-1:0] used, fill_after, done_val, drop;
  logic [SW-1:0] wp_inc, rp_inc, peek_sum, peek_at, drop_sum, drop_at;
  logic          do_fetch;

  assign wp_e  = SW'(wp);
  assign rp_e  = SW'(rp);
  assign cap_e = SW'(cfg.capacity);
  assign len   = cap_e + SW'(1);
  assign cnt_e = SW'(op_count);

  assign used     = (wp_e >= rp_e) ? (wp_e - rp_e) : (wp_e + len - rp_e);
  assign wp_inc   = (wp_e + SW'(1) == len) ? '0 : (wp_e + SW'(1));
  assign rp_inc   = (rp_e + SW'(1) == len) ? '0 : (rp_e + SW'(1));
  assign peek_sum = rp_e + cnt_e;
  assign peek_at  = (peek_sum >= len) ? (peek_sum - len) : peek_sum;
  assign drop     = (cnt_e < used) ? cnt_e : used;
  assign drop_sum = rp_e + drop;
  assign drop_at  = (drop_sum >= len) ? (drop_sum - len) : drop_sum;

  always_comb begin
    state_next     = state;
    wp_next        = wp;
    rp_next        = rp;
    peak_next      = peak;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = wp;
    mem_wdata      = op_data;
    mem_raddr      = rp;
    fill_after     = used;
    done_val       = '0;
    do_fetch       = 1'b0;
    res_valid_next = 1'b0;
    dout_next      = dout;

    unique case (state)
      IDLE: begin
        if (start) begin
          state_next = CALC;
        end
      end
      CALC: begin
        unique case (op_func)
          FUNC_WRITE: begin
            if (used < cap_e) begin
              mem_we     = 1'b1;
              wp_next    = AW'(wp_inc);
              fill_after = used + SW'(1);
              done_val   = SW'(1);
            end
            if (fill_after > SW'(peak)) begin
              peak_next = CAP_W'(fill_after);
            end
          end
          FUNC_READ: begin
            if (used != '0) begin
              mem_re     = 1'b1;
              rp_next    = AW'(rp_inc);
              fill_after = used - SW'(1);
              done_val   = SW'(1);
              do_fetch   = 1'b1;
            end
          end
          FUNC_PEEK: begin
            if (cnt_e < used) begin
              mem_re    = 1'b1;
              mem_raddr = AW'(peek_at);
              done_val  = SW'(1);
              do_fetch  = 1'b1;
            end
          end
          FUNC_CONSUME: begin
            rp_next    = AW'(drop_at);
            fill_after = used - drop;
            done_val   = drop;
          end
          FUNC_RESET: begin
            rp_next    = wp;
            peak_next  = '0;
            fill_after = '0;
          end
          default: begin
          end
        endcase
        state_next     = do_fetch ? FETCH : IDLE;
        res_valid_next = ~do_fetch;
        dout_next      = '0;
      end
      FETCH: begin
        state_next     = IDLE;
        res_valid_next = 1'b1;
        dout_next      = mem_rdata;
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      wp        <= '0;
      rp        <= '0;
      peak      <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
      if (cfg.flush) begin
        wp   <= '0;
        rp   <= '0;
        peak <= '0;
      end else begin
        wp   <= wp_next;
        rp   <= rp_next;
        peak <= peak_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    dout <= dout_next;
    if (state == IDLE && start) begin
      op_func  <= func;
      op_data  <= data_in;
      op_count <= count;
    end
    if (state == CALC) begin
      done_q <= CAP_W'(done_val);
      fill_q <= CAP_W'(fill_after);
      free_q <= CAP_W'(cap_e - fill_after);
    end
  end

  assign busy       = (state != IDLE);
  assign data_out   = dout;
  assign done_res   = done_q;
  assign fill_level = fill_q;
  assign free_space = free_q;
  assign peak_fill  = peak;

endmodule

[rtl/brf_chk.sv]
`timescale 1ns / 1ps
// brf_chk: port-level checks for the byte ring FIFO, bound to the top level.
// Depends on brf_pkg and byte_ring_fifo_with_peak_unit.
module brf_chk import brf_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              res_valid,
  input logic [DATA_W-1:0] data_out,
  input logic [CAP_W-1:0]  done_res
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !busy)
    else $error("result strobe while still busy");

  a_result_single: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> !res_valid)
    else $error("two result strobes back to back");

  a_byte_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && data_out != '0 |-> done_res == CAP_W'(1))
    else $error("byte returned without a moved count of one");

endmodule

bind byte_ring_fifo_with_peak_unit brf_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .res_valid (res_valid),
  .data_out  (data_out),
  .done_res  (done_res)
);
